// ===== design/ofta_pkg.sv =====
package ofta_pkg;

    localparam int QW    = 16;  // quaternion component width
    localparam int PW    = 32;  // position width
    localparam int MW    = 20;  // rounded matrix entry width
    localparam int OPW   = 22;  // second multiplier operand width
    localparam int VW    = 42;  // vector operand width (delta and body-frame vector)
    localparam int PRW   = MW + OPW;
    localparam int ACCW  = 64;
    localparam int SPLIT = 21;  // the low half of a vector operand
    localparam int NPROD = 10;  // distinct products of one quaternion
    localparam int NMAT  = 9;

    typedef logic signed [QW-1:0]   quat_t;
    typedef logic signed [PW-1:0]   pos_t;
    typedef logic signed [MW-1:0]   mat_t;
    typedef logic signed [VW-1:0]   vec_t;
    typedef logic signed [PW-1:0]   prod_t;
    typedef logic signed [ACCW-1:0] acc_t;

    typedef struct packed {
        logic issue;
        logic clear;
        logic hi;
    } mac_ctl_t;

    // Component pairs for ww, xx, yy, zz, xy, wz, xz, wy, yz, wx.
    localparam logic [1:0] PROD_A [NPROD] =
        '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0};
    localparam logic [1:0] PROD_B [NPROD] =
        '{2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd3, 2'd3, 2'd2, 2'd3, 2'd1};

    // One entry of the rotation matrix, row-major, rounded from Q.28 to Q.14.
    function automatic mat_t mat_entry(input prod_t p [NPROD], input logic [3:0] e);
        logic signed [35:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;
        logic signed [35:0] s;
        logic signed [35:0] r;
        ww = 36'(p[0]);
        xx = 36'(p[1]);
        yy = 36'(p[2]);
        zz = 36'(p[3]);
        xy = 36'(p[4]);
        wz = 36'(p[5]);
        xz = 36'(p[6]);
        wy = 36'(p[7]);
        yz = 36'(p[8]);
        wx = 36'(p[9]);
        case (e)
            4'd0:    s = ww + xx - yy - zz;
            4'd1:    s = (xy + wz) <<< 1;
            4'd2:    s = (xz - wy) <<< 1;
            4'd3:    s = (xy - wz) <<< 1;
            4'd4:    s = ww - xx + yy - zz;
            4'd5:    s = (yz + wx) <<< 1;
            4'd6:    s = (xz + wy) <<< 1;
            4'd7:    s = (yz - wx) <<< 1;
            4'd8:    s = ww - xx - yy + zz;
            default: s = '0;
        endcase
        r = (s + 36'sd8192) >>> 14;
        return r[MW-1:0];
    endfunction

endpackage

// ===== design/ofta_mac.sv =====
module ofta_mac (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ofta_pkg::mac_ctl_t              ctl,
    input  logic signed [ofta_pkg::MW-1:0]  a,
    input  logic signed [ofta_pkg::OPW-1:0] b,
    output logic signed [ofta_pkg::ACCW-1:0] acc
);
    import ofta_pkg::*;

    // Multiply stage, then accumulate stage; a term is registered in prod_reg, then added into acc_reg.
    logic signed [PRW-1:0] prod_reg;
    logic signed [PRW-1:0] prod_next;
    mac_ctl_t              ctl_reg;
    acc_t                  acc_reg;
    acc_t                  addend;

    assign prod_next = a * b;
    assign addend    = ctl_reg.hi ? (ACCW'(prod_reg) <<< SPLIT) : ACCW'(prod_reg);
    assign acc       = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (ctl_reg.issue)
        begin
            acc_reg <= (ctl_reg.clear ? '0 : acc_reg) + addend;
        end
    end

endmodule

// ===== design/odometry_frame_transfer_accumulator_top.sv =====
// An odometry sample (tuser = 0) is accepted, then worked through one shared
// multiply-accumulate unit until m_tvalid rises. The block is ready again once the
// result has entered the output register, so it takes no new sample while one is
// in work. An orientation update (tuser = 1) gives no result. Reset (rst_n low,
// asynchronous) sets the orientation to identity, clears the positions and marks
// the next sample as the first.
module odometry_frame_transfer_accumulator_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, quat_w, quat_x, quat_y, quat_z
    input  logic [159:0] s_tdata,
    // mode
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z, out_qw, out_qx, out_qy, out_qz
    output logic [159:0] m_tdata,
    // saturated
    output logic [0:0]   m_tuser
);
    import ofta_pkg::*;

    // The sequencer walks four phases: the ten products of each quaternion, the two
    // rotation matrices built from them, the body-frame vector and the world-frame
    // move. Each dot product issues six half-width terms and then waits for the
    // multiply-accumulate pipeline to drain.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PROD  = 3'd1;
    localparam logic [2:0] ST_MAT   = 3'd2;
    localparam logic [2:0] ST_BODY  = 3'd3;
    localparam logic [2:0] ST_WORLD = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    localparam logic [4:0] PROD_LAST = 5'd21;
    localparam logic [4:0] MAT_LAST  = 5'd17;
    localparam logic [4:0] DOT_LAST  = 5'd7;

    localparam logic signed [50:0] SAT_MAX = 51'sd2147483647;
    localparam logic signed [50:0] SAT_MIN = -51'sd2147483648;

    logic [2:0] state_reg;
    logic [4:0] idx_reg;
    logic [1:0] row_reg;
    logic       first_reg;
    logic       sat_reg;
    logic       m_tvalid_reg;
    logic [159:0] m_tdata_reg;
    logic       m_tuser_reg;

    quat_t qs_reg     [4];
    quat_t orient_reg [4];
    pos_t  prev_reg   [3];
    pos_t  accum_reg  [3];
    vec_t  d_reg      [3];
    vec_t  b_reg      [3];
    prod_t prod_reg   [2*NPROD];
    mat_t  ms_reg     [NMAT];
    mat_t  mo_reg     [NMAT];

    prod_t prod_s [NPROD];
    prod_t prod_o [NPROD];

    mac_ctl_t          mac_ctl;
    mat_t              mac_a;
    logic signed [OPW-1:0] mac_b;
    vec_t              mac_v;
    acc_t              acc;
    acc_t              acc_rnd;
    logic signed [50:0] world_sum;

    logic       accept;
    logic       mode;
    logic [3:0] pair;
    logic [1:0] term_j;
    logic [3:0] ms_idx;
    logic [3:0] mo_idx;
    quat_t      qa;
    quat_t      qb;
    logic       out_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign mode     = s_tuser[0];
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb
    begin
        for (int i = 0; i < NPROD; i++)
        begin
            prod_s[i] = prod_reg[i];
            prod_o[i] = prod_reg[NPROD + i];
        end
    end

    // Operand selection for the shared unit.
    assign pair   = (idx_reg < 5'(NPROD)) ? idx_reg[3:0] : 4'(idx_reg - 5'(NPROD));
    assign term_j = idx_reg[2:1];
    assign ms_idx = 4'({2'b00, row_reg} * 4'd3) + {2'b00, term_j};
    assign mo_idx = 4'({2'b00, term_j} * 4'd3) + {2'b00, row_reg};

    always_comb
    begin
        if (idx_reg < 5'(NPROD))
        begin
            qa = qs_reg[PROD_A[pair]];
            qb = qs_reg[PROD_B[pair]];
        end
        else
        begin
            qa = orient_reg[PROD_A[pair]];
            qb = orient_reg[PROD_B[pair]];
        end
    end

    always_comb
    begin
        mac_ctl = '0;
        mac_a   = MW'(qa);
        mac_v   = b_reg[term_j];
        mac_b   = OPW'(qb);
        unique case (state_reg)
            ST_PROD:
            begin
                mac_ctl.issue = (idx_reg < 5'(2*NPROD));
                mac_ctl.clear = 1'b1;
            end
            ST_BODY:
            begin
                mac_a = ms_reg[ms_idx];
                mac_v = d_reg[term_j];
                mac_ctl.issue = (idx_reg < 5'd6);
                mac_ctl.clear = (idx_reg == 5'd0);
                mac_ctl.hi    = idx_reg[0];
                mac_b = idx_reg[0] ? {mac_v[VW-1], mac_v[VW-1:SPLIT]}
                                   : {1'b0, mac_v[SPLIT-1:0]};
            end
            ST_WORLD:
            begin
                mac_a = mo_reg[mo_idx];
                mac_ctl.issue = (idx_reg < 5'd6);
                mac_ctl.clear = (idx_reg == 5'd0);
                mac_ctl.hi    = idx_reg[0];
                mac_b = idx_reg[0] ? {mac_v[VW-1], mac_v[VW-1:SPLIT]}
                                   : {1'b0, mac_v[SPLIT-1:0]};
            end
            default:
            begin
                mac_ctl = '0;
            end
        endcase
    end

    ofta_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .a     (mac_a),
        .b     (mac_b),
        .acc   (acc)
    );

    assign acc_rnd   = (acc + 64'sd8192) >>> 14;
    assign world_sum = 51'(accum_reg[row_reg]) + acc_rnd[50:0];

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            row_reg      <= '0;
            first_reg    <= 1'b1;
            m_tvalid_reg <= 1'b0;
            prev_reg     <= '{default: '0};
            accum_reg    <= '{default: '0};
            orient_reg   <= '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        end
        else
        begin
            // A new result may enter the output register in the same cycle as the
            // previous one leaves it.
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (mode)
                        begin
                            for (int i = 0; i < 4; i++)
                            begin
                                orient_reg[i] <= s_tdata[96 + 16*i +: 16];
                            end
                        end
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                prev_reg[i] <= s_tdata[32*i +: 32];
                            end
                            first_reg <= 1'b0;
                            idx_reg   <= '0;
                            state_reg <= ST_PROD;
                        end
                    end
                end
                ST_PROD:
                begin
                    if (idx_reg == PROD_LAST)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_MAT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                ST_MAT:
                begin
                    if (idx_reg == MAT_LAST)
                    begin
                        idx_reg   <= '0;
                        row_reg   <= '0;
                        state_reg <= ST_BODY;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                ST_BODY:
                begin
                    if (idx_reg == DOT_LAST)
                    begin
                        idx_reg <= '0;
                        if (row_reg == 2'd2)
                        begin
                            row_reg   <= '0;
                            state_reg <= ST_WORLD;
                        end
                        else
                        begin
                            row_reg <= row_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                ST_WORLD:
                begin
                    if (idx_reg == DOT_LAST)
                    begin
                        idx_reg <= '0;
                        if (world_sum > SAT_MAX)
                        begin
                            accum_reg[row_reg] <= SAT_MAX[PW-1:0];
                        end
                        else if (world_sum < SAT_MIN)
                        begin
                            accum_reg[row_reg] <= SAT_MIN[PW-1:0];
                        end
                        else
                        begin
                            accum_reg[row_reg] <= world_sum[PW-1:0];
                        end
                        if (row_reg == 2'd2)
                        begin
                            row_reg   <= '0;
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            row_reg <= row_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 5'd1;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Working data.
    always_ff @(posedge clk)
    begin
        if (accept && !mode)
        begin
            sat_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                qs_reg[i] <= s_tdata[96 + 16*i +: 16];
            end
            for (int i = 0; i < 3; i++)
            begin
                // The first sample moves nothing.
                if (first_reg)
                begin
                    d_reg[i] <= '0;
                end
                else
                begin
                    d_reg[i] <= VW'(signed'(s_tdata[32*i +: 32])) - VW'(prev_reg[i]);
                end
            end
        end
        if ((state_reg == ST_PROD) && (idx_reg >= 5'd2))
        begin
            prod_reg[idx_reg - 5'd2] <= acc[PW-1:0];
        end
        if (state_reg == ST_MAT)
        begin
            if (idx_reg < 5'(NMAT))
            begin
                ms_reg[idx_reg[3:0]] <= mat_entry(prod_s, idx_reg[3:0]);
            end
            else
            begin
                mo_reg[4'(idx_reg - 5'(NMAT))] <= mat_entry(prod_o, 4'(idx_reg - 5'(NMAT)));
            end
        end
        if ((state_reg == ST_BODY) && (idx_reg == DOT_LAST))
        begin
            b_reg[row_reg] <= acc_rnd[VW-1:0];
        end
        if ((state_reg == ST_WORLD) && (idx_reg == DOT_LAST))
        begin
            if ((world_sum > SAT_MAX) || (world_sum < SAT_MIN))
            begin
                sat_reg <= 1'b1;
            end
        end
        if (out_load)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_tdata_reg[32*i +: 32] <= accum_reg[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                m_tdata_reg[96 + 16*i +: 16] <= orient_reg[i];
            end
            m_tuser_reg <= sat_reg;
        end
    end

endmodule

// ===== test/odometry_frame_transfer_accumulator_top_tb.sv =====
`timescale 1ns / 1ps

module odometry_frame_transfer_accumulator_top_tb;

    import ofta_pkg::*;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_ORIENT = 1'b1;
    localparam int N_RANDOM    = 1400;
    localparam int LATENCY     = 100;
    localparam longint CYCLE_LIMIT = 2000000;

    // One result item as it appears on the output bus, highest bits first.
    typedef struct packed {
        logic signed [15:0] qz;
        logic signed [15:0] qy;
        logic signed [15:0] qx;
        logic signed [15:0] qw;
        logic signed [31:0] z;
        logic signed [31:0] y;
        logic signed [31:0] x;
        logic               sat;
    } pose_t;

    // Tracks the block's state and holds the poses still to come out.
    class pose_scoreboard;
        bit               first;
        longint           prev [3];
        longint           accum [3];
        logic signed [15:0] orient [4];
        pose_t            pending [$];
        int               errors;

        function new();
            first = 1;
            for (int i = 0; i < 3; i++)
            begin
                prev[i] = 0;
                accum[i] = 0;
            end
            orient[0] = 16384;
            orient[1] = 0;
            orient[2] = 0;
            orient[3] = 0;
            errors = 0;
        endfunction

        // Round half up from 14 extra fraction bits; >>> on longint is arithmetic.
        function longint round14(longint v);
            return (v + 64'sd8192) >>> 14;
        endfunction

        function void rotation(input longint q [4], output longint m [3][3]);
            longint w, x, y, z;
            w = q[0];
            x = q[1];
            y = q[2];
            z = q[3];
            m[0][0] = round14(w*w + x*x - y*y - z*z);
            m[0][1] = round14(2 * (x*y + w*z));
            m[0][2] = round14(2 * (x*z - w*y));
            m[1][0] = round14(2 * (x*y - w*z));
            m[1][1] = round14(w*w - x*x + y*y - z*z);
            m[1][2] = round14(2 * (y*z + w*x));
            m[2][0] = round14(2 * (x*z + w*y));
            m[2][1] = round14(2 * (y*z - w*x));
            m[2][2] = round14(w*w - x*x - y*y + z*z);
        endfunction

        function void note_input(logic mode, logic signed [31:0] p [3],
                                 logic signed [15:0] q [4]);
            longint qs [4];
            longint qo [4];
            longint ms [3][3];
            longint mo [3][3];
            longint d [3];
            longint b [3];
            longint s;
            pose_t  r;
            if (mode == MODE_ORIENT)
            begin
                for (int i = 0; i < 4; i++)
                    orient[i] = q[i];
                return;
            end
            if (first)
                for (int i = 0; i < 3; i++)
                    prev[i] = p[i];
            for (int i = 0; i < 4; i++)
            begin
                qs[i] = q[i];
                qo[i] = orient[i];
            end
            for (int i = 0; i < 3; i++)
                d[i] = longint'(p[i]) - prev[i];
            rotation(qs, ms);
            rotation(qo, mo);
            for (int i = 0; i < 3; i++)
            begin
                s = 0;
                for (int j = 0; j < 3; j++)
                    s += ms[i][j] * d[j];
                b[i] = round14(s);
            end
            r.sat = 0;
            for (int i = 0; i < 3; i++)
            begin
                s = 0;
                for (int j = 0; j < 3; j++)
                    s += mo[j][i] * b[j];
                accum[i] = accum[i] + round14(s);
                if (accum[i] > 64'sd2147483647)
                begin
                    accum[i] = 64'sd2147483647;
                    r.sat = 1;
                end
                else if (accum[i] < -64'sd2147483648)
                begin
                    accum[i] = -64'sd2147483648;
                    r.sat = 1;
                end
            end
            for (int i = 0; i < 3; i++)
                prev[i] = p[i];
            first = 0;
            r.x = accum[0][31:0];
            r.y = accum[1][31:0];
            r.z = accum[2][31:0];
            r.qw = orient[0];
            r.qx = orient[1];
            r.qy = orient[2];
            r.qz = orient[3];
            pending.push_back(r);
        endfunction

        function void check_result(pose_t got);
            pose_t exp;
            if (pending.size() == 0)
            begin
                $error("unexpected result item %h", got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.x !== exp.x)
            begin
                $error("out_x expected %0d got %0d", exp.x, got.x);
                errors++;
            end
            if (got.y !== exp.y)
            begin
                $error("out_y expected %0d got %0d", exp.y, got.y);
                errors++;
            end
            if (got.z !== exp.z)
            begin
                $error("out_z expected %0d got %0d", exp.z, got.z);
                errors++;
            end
            if (got.qw !== exp.qw)
            begin
                $error("out_qw expected %0d got %0d", exp.qw, got.qw);
                errors++;
            end
            if (got.qx !== exp.qx)
            begin
                $error("out_qx expected %0d got %0d", exp.qx, got.qx);
                errors++;
            end
            if (got.qy !== exp.qy)
            begin
                $error("out_qy expected %0d got %0d", exp.qy, got.qy);
                errors++;
            end
            if (got.qz !== exp.qz)
            begin
                $error("out_qz expected %0d got %0d", exp.qz, got.qz);
                errors++;
            end
            if (got.sat !== exp.sat)
            begin
                $error("saturated expected %0d got %0d", exp.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [159:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;
    logic [0:0]   m_tuser;

    pose_scoreboard poses;
    longint cycles;
    bit     quiet_in;       // no idling on the input side
    bit     quiet_out;      // no stalling on the output side
    int     hold_off;       // cycles the receiver still holds off

    odometry_frame_transfer_accumulator_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 0;
    end

    always #5 clk = ~clk;

    // The cycle counter guards against a block that hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("odometry_frame_transfer_accumulator_top_tb failed");
            $finish;
        end
    end

    // The receiver: random stalls, or a long counted hold-off when one is armed.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            m_tready <= 0;
        end
        else
            m_tready <= quiet_out || ($urandom_range(99) >= 32);
    end

    // Each accepted result item goes straight to the scoreboard.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            poses.check_result({m_tdata, m_tuser[0]});
    end

    // Offers one item, idling at random beforehand, and waits for its acceptance.
    // The prediction is made at the acceptance edge, in the same order as the block.
    // tvalid stays high after acceptance; the next item or an idle cycle replaces it.
    task automatic send_item(logic mode, logic signed [31:0] p [3], logic signed [15:0] q [4]);
        bit idle;
        idle = !quiet_in && ($urandom_range(99) < 32);
        if (idle)
            s_tvalid <= 0;
        while (idle)
        begin
            @(posedge clk);
            idle = !quiet_in && ($urandom_range(99) < 32);
        end
        s_tvalid <= 1;
        s_tuser  <= mode;
        s_tdata  <= {q[3], q[2], q[1], q[0], p[2], p[1], p[0]};
        do
            @(posedge clk);
        while (!s_tready);
        poses.note_input(mode, p, q);
    endtask

    // A random position moves a modest way half the time; otherwise it is anywhere in range or at an extreme.
    function automatic logic signed [31:0] random_pos();
        case ($urandom_range(3))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(2000000)) - 1000000;
        endcase
    endfunction

    // Mostly moderate quaternion components, with full-scale and raw values mixed in.
    function automatic void random_quat(output logic signed [15:0] q [4]);
        int pick;
        pick = $urandom_range(9);
        for (int i = 0; i < 4; i++)
        begin
            if (pick == 0)
                q[i] = 16'($urandom);
            else if (pick == 1)
                q[i] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
            else
                q[i] = 16'($signed($urandom_range(16384)) - 8192);
        end
    endfunction

    task automatic wait_drained();
        s_tvalid <= 0;
        while (poses.pending.size() != 0)
            @(posedge clk);
    endtask

    logic signed [31:0] p [3];
    logic signed [15:0] q [4];

    initial
    begin
        poses     = new();
        cycles    = 0;
        rst_n     = 0;
        s_tvalid  = 0;
        s_tdata   = '0;
        s_tuser   = '0;
        m_tready  = 0;
        quiet_in  = 0;
        quiet_out = 0;
        hold_off  = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: first sample, orientation updates, extremes and saturation.
        p = '{32'sd65536, -32'sd65536, 32'sd0};
        q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        send_item(MODE_SAMPLE, p, q);
        p = '{32'sd131072, 32'sd65536, 32'sd1000};
        send_item(MODE_SAMPLE, p, q);
        q = '{16'sd11585, 16'sd0, 16'sd0, 16'sd11585};
        send_item(MODE_ORIENT, p, q);
        p = '{32'sd300000, -32'sd70000, 32'sd5};
        send_item(MODE_SAMPLE, p, q);
        q = '{-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384};
        send_item(MODE_SAMPLE, p, q);
        q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        send_item(MODE_SAMPLE, p, q);
        p = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        send_item(MODE_SAMPLE, p, q);
        send_item(MODE_SAMPLE, p, q);
        p = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
        send_item(MODE_SAMPLE, p, q);
        send_item(MODE_SAMPLE, p, q);
        p = '{32'sh80000000, 32'sh80000000, 32'sh80000000};
        send_item(MODE_SAMPLE, p, q);
        q = '{16'sh7fff, 16'sh8000, 16'shffff, 16'sh5555};
        send_item(MODE_ORIENT, p, q);
        p = '{32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff};
        q = '{16'shaaaa, 16'sh7fff, 16'sh8000, 16'sh0001};
        send_item(MODE_SAMPLE, p, q);
        q = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        send_item(MODE_ORIENT, p, q);

        // The sender pauses here until every expected result has come out.
        wait_drained();

        // Long receiver hold-off while the sender keeps offering items.
        hold_off <= 400;
        for (int k = 0; k < 6; k++)
        begin
            for (int i = 0; i < 3; i++)
                p[i] = random_pos();
            random_quat(q);
            send_item(MODE_SAMPLE, p, q);
        end

        // Random part, with a quiet stretch on both sides in the middle.
        for (int n = 0; n < N_RANDOM; n++)
        begin
            quiet_in  <= (n >= 500 && n < 700);
            quiet_out <= (n >= 500 && n < 700);
            for (int i = 0; i < 3; i++)
                p[i] = random_pos();
            random_quat(q);
            send_item(($urandom_range(4) == 0) ? MODE_ORIENT : MODE_SAMPLE, p, q);
        end

        wait_drained();
        repeat (LATENCY) @(posedge clk);
        if (poses.errors == 0 && poses.pending.size() == 0)
            $display("odometry_frame_transfer_accumulator_top_tb passed");
        else
            $display("odometry_frame_transfer_accumulator_top_tb failed");
        $finish;
    end

endmodule
